@@ src/spbmm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spbmm_pkg
// Shared types and constants of the sparse Boolean matrix product block:
// request and status codes, field widths, register map and defaults.
// ----------------------------------------------------------------------------
package spbmm_pkg;

	// Field widths
	localparam int IDX_W = 8;
	localparam int DIM_W = 9;

	// Default sizes
	localparam int DEF_MAX_DIM = 256;
	localparam int DEF_MAX_NNZ = 4096;

	// Configuration port
	localparam int                 PADDR_W   = 3;
	localparam logic [PADDR_W-3:0] REG_DIM   = '0;
	localparam logic [DIM_W-1:0]   DIM_RESET = 9'd256;

	// Request codes
	typedef enum logic [1:0] {
		REQ_LOAD_A = 2'd0,
		REQ_LOAD_B = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_LOCKED = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ src/spbmm_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spbmm request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------

// Request channel: load, query or clear
interface spbmm_req_if import spbmm_pkg::*; ();
	logic             valid;
	logic             ready;
	req_type_t        req_type;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;

	modport source (output valid, output req_type, output row_index, output col_index,
		input ready);
	modport sink (input valid, input req_type, input row_index, input col_index,
		output ready);
endinterface

// Response channel: product bit and status
interface spbmm_rsp_if import spbmm_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    found;
	status_t status;

	modport source (output valid, output found, output status, input ready);
	modport sink (input valid, input found, input status, output ready);
endinterface

`default_nettype wire

@@ src/sparse_boolean_matmul_csr_csc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_boolean_matmul_csr_csc
// Boolean sparse matrix product: A kept row-compressed, B column-compressed,
// one product bit C[i][j] answered per query by merging two sorted lists.
// ----------------------------------------------------------------------------
// One item is handled at a time; ready is low while it is worked on, and a
// finished result waits in the output register while the next item is taken.
// A load stores the entry and advances its count, then increments its pointer
// entry; a clear sweeps the pointer memories; a query reads the list bounds
// and merges, with at most the two list lengths added, less one, advances. A
// rejected load goes straight to its result. Ready returns in the same cycle
// as the result is registered. The first query after loading also runs the
// prefix sum over the pointer entries of each matrix, A then B. The sequence
// of steps follows from the single read port of each pointer memory and the
// one shared adder. After reset the pointer memories are cleared in a pass
// during which no item is taken; configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module sparse_boolean_matmul_csr_csc import spbmm_pkg::*; #(
	parameter int MAX_DIM = DEF_MAX_DIM,
	parameter int MAX_NNZ = DEF_MAX_NNZ
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	spbmm_req_if.sink               req,
	spbmm_rsp_if.source             rsp
);

	localparam int PTR_AW = $clog2(MAX_DIM + 1);
	localparam int PTR_D  = 1 << PTR_AW;
	localparam int CNT_W  = $clog2(MAX_NNZ + 1);
	localparam int NNZ_AW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
	localparam int XW     = PTR_AW + IDX_W;

	typedef enum logic [12:0] {
		S_CLR    = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_LD_RD  = 13'b0000000000100,
		S_LD_WR  = 13'b0000000001000,
		S_PFX_RD = 13'b0000000010000,
		S_PFX_WR = 13'b0000000100000,
		S_QCHK   = 13'b0000001000000,
		S_Q0     = 13'b0000010000000,
		S_Q1     = 13'b0000100000000,
		S_Q2     = 13'b0001000000000,
		S_MRD    = 13'b0010000000000,
		S_MCMP   = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   dim_q;
	logic [CNT_W-1:0]   a_cnt_q, b_cnt_q;
	logic               built_q;
	logic               clr_reply_q;
	logic               side_b_q;
	logic [PTR_AW-1:0]  sweep_q;
	logic [CNT_W-1:0]   acc_q;
	logic [IDX_W-1:0]   row_q, col_q;
	logic [CNT_W-1:0]   pa_q, ea_q, pb_q, eb_q;
	logic               res_found_q;
	status_t            res_status_q;
	logic               rsp_valid_q;
	logic               rsp_found_q;
	status_t            rsp_status_q;

	// Memories
	logic [CNT_W-1:0]   ptr_a_mem [PTR_D];
	logic [CNT_W-1:0]   ptr_b_mem [PTR_D];
	logic [IDX_W-1:0]   a_store_mem [MAX_NNZ];
	logic [IDX_W-1:0]   b_store_mem [MAX_NNZ];
	logic [CNT_W-1:0]   ptr_a_rdata_q, ptr_b_rdata_q;
	logic [IDX_W-1:0]   a_store_rdata_q, b_store_rdata_q;

	logic [PTR_AW-1:0]  ptr_a_raddr, ptr_b_raddr, ptr_waddr;
	logic               ptr_a_we, ptr_b_we;
	logic [CNT_W-1:0]   ptr_wdata;
	logic               a_store_we, b_store_we;

	logic [CNT_W-1:0]   add_x, add_y, add_sum;
	logic [CNT_W-1:0]   ptr_rdata_side;
	logic               a_lt_b;
	logic [IDX_W-1:0]   grp, member;
	logic [XW-1:0]      grp_x, row_x, col_x;
	logic [PTR_AW-1:0]  grp_p1, sweep_p1;
	logic               cfg_we;
	logic               in_fire;
	logic               out_free;

	// Index check against the dimension in use and against MAX_DIM
	function automatic logic idx_ok(input logic [IDX_W-1:0] x, input logic [DIM_W-1:0] d);
		return (32'(x) < 32'(d)) && (32'(x) < MAX_DIM);
	endfunction

	// Configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_DIM);
	assign prdata = (paddr[PADDR_W-1:2] == REG_DIM) ? 32'(dim_q) : '0;

	// Handshakes
	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.found  = rsp_found_q;
	assign rsp.status = rsp_status_q;

	// Address arithmetic for the pointer memories
	assign grp      = side_b_q ? col_q : row_q;
	assign member   = side_b_q ? row_q : col_q;
	assign grp_x    = XW'(grp);
	assign row_x    = XW'(row_q);
	assign col_x    = XW'(col_q);
	assign grp_p1   = PTR_AW'(grp_x + XW'(1));
	assign sweep_p1 = sweep_q + PTR_AW'(1);

	assign ptr_rdata_side = side_b_q ? ptr_b_rdata_q : ptr_a_rdata_q;
	assign a_lt_b         = a_store_rdata_q < b_store_rdata_q;

	// Shared adder: counts, pointer increments, prefix sum, merge advance
	always_comb begin
		add_x = '0;
		add_y = '0;
		unique case (state_q)
			S_LD_RD: begin
				add_x = side_b_q ? b_cnt_q : a_cnt_q;
				add_y = CNT_W'(1);
			end
			S_LD_WR: begin
				add_x = ptr_rdata_side;
				add_y = CNT_W'(1);
			end
			S_PFX_WR: begin
				add_x = ptr_rdata_side;
				add_y = acc_q;
			end
			S_MCMP: begin
				add_x = a_lt_b ? pa_q : pb_q;
				add_y = CNT_W'(1);
			end
			default: begin
				add_x = '0;
				add_y = '0;
			end
		endcase
	end
	assign add_sum = add_x + add_y;

	// Pointer memory control
	always_comb begin
		ptr_a_raddr = grp_p1;
		ptr_b_raddr = grp_p1;
		ptr_a_we    = 1'b0;
		ptr_b_we    = 1'b0;
		ptr_waddr   = grp_p1;
		ptr_wdata   = add_sum;
		unique case (state_q)
			S_CLR: begin
				ptr_a_we  = 1'b1;
				ptr_b_we  = 1'b1;
				ptr_waddr = sweep_q;
				ptr_wdata = '0;
			end
			S_LD_WR: begin
				ptr_a_we = !side_b_q;
				ptr_b_we = side_b_q;
			end
			S_PFX_RD: begin
				ptr_a_raddr = sweep_p1;
				ptr_b_raddr = sweep_p1;
			end
			S_PFX_WR: begin
				ptr_a_we  = !side_b_q;
				ptr_b_we  = side_b_q;
				ptr_waddr = sweep_p1;
			end
			S_Q0: begin
				ptr_a_raddr = PTR_AW'(row_x);
				ptr_b_raddr = PTR_AW'(col_x);
			end
			S_Q1: begin
				ptr_a_raddr = PTR_AW'(row_x + XW'(1));
				ptr_b_raddr = PTR_AW'(col_x + XW'(1));
			end
			default: begin
				ptr_a_we = 1'b0;
				ptr_b_we = 1'b0;
			end
		endcase
	end

	assign a_store_we = (state_q == S_LD_RD) && !side_b_q;
	assign b_store_we = (state_q == S_LD_RD) && side_b_q;

	// Pointer memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (ptr_a_we) begin
			ptr_a_mem[ptr_waddr] <= ptr_wdata;
		end
		ptr_a_rdata_q <= ptr_a_mem[ptr_a_raddr];
	end

	always_ff @(posedge clk) begin
		if (ptr_b_we) begin
			ptr_b_mem[ptr_waddr] <= ptr_wdata;
		end
		ptr_b_rdata_q <= ptr_b_mem[ptr_b_raddr];
	end

	// Index stores: written at the entry count, read at the merge cursors
	always_ff @(posedge clk) begin
		if (a_store_we) begin
			a_store_mem[a_cnt_q[NNZ_AW-1:0]] <= member;
		end
		a_store_rdata_q <= a_store_mem[pa_q[NNZ_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (b_store_we) begin
			b_store_mem[b_cnt_q[NNZ_AW-1:0]] <= member;
		end
		b_store_rdata_q <= b_store_mem[pb_q[NNZ_AW-1:0]];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			dim_q        <= DIM_RESET;
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			built_q      <= 1'b0;
			clr_reply_q  <= 1'b0;
			side_b_q     <= 1'b0;
			sweep_q      <= '0;
			acc_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			pa_q         <= '0;
			ea_q         <= '0;
			pb_q         <= '0;
			eb_q         <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_found_q  <= 1'b0;
			rsp_status_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				dim_q <= pwdata[DIM_W-1:0];
			end

			// Load a finished result into the output register, drop it once taken
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q  <= 1'b1;
				rsp_found_q  <= res_found_q;
				rsp_status_q <= res_status_q;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					if (sweep_q == PTR_AW'(MAX_DIM)) begin
						sweep_q <= '0;
						state_q <= clr_reply_q ? S_DONE : S_IDLE;
					end else begin
						sweep_q <= sweep_p1;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						row_q       <= req.row_index;
						col_q       <= req.col_index;
						side_b_q    <= (req.req_type == REQ_LOAD_B);
						res_found_q <= 1'b0;
						case (req.req_type) inside
							REQ_LOAD_A, REQ_LOAD_B: begin
								if (built_q) begin
									res_status_q <= ST_LOCKED;
									state_q      <= S_DONE;
								end else if (!idx_ok(req.row_index, dim_q) ||
								             !idx_ok(req.col_index, dim_q)) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else if (32'((req.req_type == REQ_LOAD_B) ? b_cnt_q : a_cnt_q)
								             >= MAX_NNZ) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_LD_RD;
								end
							end
							REQ_QUERY: begin
								res_status_q <= (!idx_ok(req.row_index, dim_q) ||
								                 !idx_ok(req.col_index, dim_q)) ? ST_RANGE : ST_OK;
								if (built_q) begin
									state_q <= S_QCHK;
								end else begin
									sweep_q <= '0;
									acc_q   <= '0;
									state_q <= S_PFX_RD;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								a_cnt_q      <= '0;
								b_cnt_q      <= '0;
								built_q      <= 1'b0;
								clr_reply_q  <= 1'b1;
								sweep_q      <= '0;
								state_q      <= S_CLR;
							end
						endcase
					end
				end
				S_LD_RD: begin
					// Store the entry and advance its count
					if (side_b_q) begin
						b_cnt_q <= add_sum;
					end else begin
						a_cnt_q <= add_sum;
					end
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					state_q <= S_DONE;
				end
				S_PFX_RD: begin
					state_q <= S_PFX_WR;
				end
				S_PFX_WR: begin
					// Accumulate counts into start offsets, A then B
					if (sweep_q == PTR_AW'(MAX_DIM - 1)) begin
						sweep_q <= '0;
						acc_q   <= '0;
						if (side_b_q) begin
							built_q <= 1'b1;
							state_q <= S_QCHK;
						end else begin
							side_b_q <= 1'b1;
							state_q  <= S_PFX_RD;
						end
					end else begin
						acc_q   <= add_sum;
						sweep_q <= sweep_p1;
						state_q <= S_PFX_RD;
					end
				end
				S_QCHK: begin
					state_q <= (res_status_q == ST_RANGE) ? S_DONE : S_Q0;
				end
				S_Q0: begin
					state_q <= S_Q1;
				end
				S_Q1: begin
					pa_q    <= ptr_a_rdata_q;
					pb_q    <= ptr_b_rdata_q;
					state_q <= S_Q2;
				end
				S_Q2: begin
					ea_q    <= ptr_a_rdata_q;
					eb_q    <= ptr_b_rdata_q;
					state_q <= S_MRD;
				end
				S_MRD: begin
					// Stop when either list runs out
					state_q <= ((pa_q < ea_q) && (pb_q < eb_q)) ? S_MCMP : S_DONE;
				end
				S_MCMP: begin
					// Compare heads: hit, or advance the smaller one
					if (a_store_rdata_q == b_store_rdata_q) begin
						res_found_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						if (a_lt_b) begin
							pa_q <= add_sum;
						end else begin
							pb_q <= add_sum;
						end
						state_q <= S_MRD;
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
